// ----- rtl/saq_pkg.sv -----
// Package for the sorted alarm queue: entry, request and result types, operation
// and status codes, and the cell control word shared by the cell row and the top level.
// Depends on nothing.
package saq_pkg;

    localparam int ID_W         = 5;
    localparam int TIME_W       = 32;
    localparam int OWNER_W      = 64;
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_DELETE = 2'd1,
        FN_FIND   = 2'd2,
        FN_EXPIRE = 2'd3
    } saq_func_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NO_ID     = 3'd1,
        STS_PAST      = 3'd2,
        STS_NOT_OWNER = 3'd3,
        STS_FULL      = 3'd4
    } saq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EXPIRE
    } saq_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } saq_cell_op_t;

    typedef struct packed {
        logic [TIME_W-1:0]  due_time;
        logic [ID_W-1:0]    id;
        logic [OWNER_W-1:0] owner;
    } saq_entry_t;

    typedef struct packed {
        saq_cell_op_t    op;
        logic [ID_W-1:0] key_id;
        saq_entry_t      ins;
    } saq_cell_ctrl_t;

    typedef struct packed {
        saq_func_t          func;
        logic [ID_W-1:0]    alarm_id;
        logic [TIME_W-1:0]  alarm_time;
        logic [OWNER_W-1:0] owner_name;
        logic               override_owner;
        logic [TIME_W-1:0]  now_time;
    } saq_req_t;

    typedef struct packed {
        saq_status_t        status;
        logic [ID_W-1:0]    out_id;
        logic [TIME_W-1:0]  out_time;
        logic [OWNER_W-1:0] out_owner;
        logic               last_result;
    } saq_rsp_t;

endpackage

// ----- rtl/saq_if.sv -----
// Request and result channel interfaces of the sorted alarm queue.
// Valid/ready handshake with the payload alongside; no dependencies.
interface saq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [4:0]  alarm_id;
    logic [31:0] alarm_time;
    logic [63:0] owner_name;
    logic        override_owner;
    logic [31:0] now_time;

    modport source (
        output valid, func, alarm_id, alarm_time, owner_name, override_owner, now_time,
        input  ready
    );
    modport sink (
        input  valid, func, alarm_id, alarm_time, owner_name, override_owner, now_time,
        output ready
    );
endinterface

interface saq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  out_id;
    logic [31:0] out_time;
    logic [63:0] out_owner;
    logic        last_result;

    modport source (
        output valid, status, out_id, out_time, out_owner, last_result,
        input  ready
    );
    modport sink (
        input  valid, status, out_id, out_time, out_owner, last_result,
        output ready
    );
endinterface

// ----- rtl/saq_cell.sv -----
// One slot of the sorted alarm row: holds an entry and trades it with its neighbors.
// Depends on saq_pkg.
module saq_cell
    import saq_pkg::*;
(
    input  logic           clk,
    input  saq_cell_ctrl_t ctrl,
    input  logic           occupied,
    input  logic           take_right,
    input  logic           after_in,
    input  saq_entry_t     left_entry,
    input  saq_entry_t     right_entry,
    output logic           after_out,
    output logic           match,
    output saq_entry_t     entry
);

    saq_entry_t entry_reg;
    saq_entry_t entry_next;

    // The new entry belongs before this slot when the slot is empty or due later.
    assign after_out = !occupied || (ctrl.ins.due_time < entry_reg.due_time);
    assign match     = occupied && (entry_reg.id == ctrl.key_id);
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (after_in)
                begin
                    entry_next = left_entry;
                end
                else if (after_out)
                begin
                    entry_next = ctrl.ins;
                end
            end
            CELL_REMOVE:
            begin
                if (take_right)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/sorted_alarm_queue_unit.sv -----
// Top level of the sorted alarm queue: request capture, sequencing FSM, result
// register and a row of saq_cell slots. Depends on saq_pkg, saq_if and saq_cell.
//
//   Channel | Direction | Carries
//   --------+-----------+---------------------------------------------------------
//   req     | in        | func, alarm_id, alarm_time, owner_name, override_owner, now_time
//   rsp     | out       | status, out_id, out_time, out_owner, last_result
//
// Add, delete and find are accepted in the idle state; in the execute state the cell
// row inserts (add) or shifts (delete) and the result register loads. Expire pops due
// entries from the head, one result per pop; when nothing is due it returns to idle
// with no result. Each pop is one shift of the whole row toward the head.
// A full result register stalls execution until the result is taken; a new request
// is accepted whenever the sequencer is idle, even while a result still waits.
// Reset clears the occupancy, the id counter, the sequencer and the result valid
// flag; the entry slots are not cleared, since only occupied slots are ever read.
module sorted_alarm_queue_unit
    import saq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ID_LIMIT   = 16,
    parameter int NAME_BYTES = 8
)
(
    input  logic clk,
    input  logic rst_n,
    saq_req_if.sink   req,
    saq_rsp_if.source rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CTR_W = $clog2(ID_LIMIT + 2);

    // Keeps the tag bytes up to the first zero byte and within NAME_BYTES.
    function automatic logic [OWNER_W-1:0] tag_norm(input logic [OWNER_W-1:0] t);
        logic [OWNER_W-1:0] r;
        logic               stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= NAME_BYTES || t[8*i +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                r[8*i +: 8] = t[8*i +: 8];
            end
        end
        return r;
    endfunction

    // Bounded string comparison: stops at the first zero byte of either tag.
    function automatic logic tag_eq(input logic [OWNER_W-1:0] a,
                                    input logic [OWNER_W-1:0] b);
        logic eq;
        logic done;
        eq   = 1'b1;
        done = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (!done && i < NAME_BYTES)
            begin
                if (a[8*i +: 8] != b[8*i +: 8])
                begin
                    eq   = 1'b0;
                    done = 1'b1;
                end
                else if (a[8*i +: 8] == 8'h00)
                begin
                    done = 1'b1;
                end
            end
        end
        return eq;
    endfunction

    saq_state_t       state_reg, state_next;
    saq_req_t         req_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [CTR_W-1:0] ctr_reg, ctr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg;
    saq_rsp_t         rsp_reg, rsp_next;

    logic             accept;
    logic             out_free;
    logic             emit;
    logic             pop;
    logic [ID_W-1:0]  new_id;

    saq_cell_ctrl_t   cell_ctrl;
    saq_entry_t       cell_entry [CAPACITY];
    logic [CAPACITY-1:0] occupied_vec;
    logic [CAPACITY-1:0] after_vec;
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] first_hot;
    logic [CAPACITY-1:0] rm_vec;
    logic [CAPACITY-1:0] take_right;
    logic                found;
    saq_entry_t          sel_entry;
    logic                head_due;
    logic                next_due;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = rsp_reg.status;
    assign rsp.out_id      = rsp_reg.out_id;
    assign rsp.out_time    = rsp_reg.out_time;
    assign rsp.out_owner   = rsp_reg.out_owner;
    assign rsp.last_result = rsp_reg.last_result;

    // The cell row. Inserts ripple a "belongs before" flag toward the tail; removals
    // pull each selected slot's content from its right neighbor.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_row
        saq_entry_t left_e;
        saq_entry_t right_e;
        logic       after_left;

        assign occupied_vec[g] = (OCC_W'(g) < occ_reg);

        if (g == 0)
        begin : g_head
            assign left_e     = '0;
            assign after_left = 1'b0;
        end
        else
        begin : g_mid
            assign left_e     = cell_entry[g-1];
            assign after_left = after_vec[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_e = cell_entry[g];
        end
        else
        begin : g_body
            assign right_e = cell_entry[g+1];
        end

        saq_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .occupied    (occupied_vec[g]),
            .take_right  (take_right[g]),
            .after_in    (after_left),
            .left_entry  (left_e),
            .right_entry (right_e),
            .after_out   (after_vec[g]),
            .match       (match_vec[g]),
            .entry       (cell_entry[g])
        );
    end

    // The first matching slot, as a one-hot vector, and every slot from it on.
    assign first_hot = match_vec & (~match_vec + CAPACITY'(1));
    assign rm_vec    = ~(first_hot - CAPACITY'(1));
    assign found     = |match_vec;

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_hot[i])
            begin
                sel_entry = sel_entry | cell_entry[i];
            end
        end
    end

    // Expire looks at the head and the slot behind it to mark the final pop.
    assign head_due = (cnt_reg < CNT_W'(RESULT_LIMIT)) && (occ_reg != '0)
                      && (cell_entry[0].due_time < req_reg.now_time);
    assign next_due = (cnt_reg < CNT_W'(RESULT_LIMIT - 1)) && (occ_reg > OCC_W'(1))
                      && (cell_entry[1].due_time < req_reg.now_time);

    assign new_id = (ctr_reg > CTR_W'(ID_LIMIT)) ? '0 : ID_W'(ctr_reg);

    always_comb
    begin
        state_next        = state_reg;
        occ_next          = occ_reg;
        ctr_next          = ctr_reg;
        cnt_next          = cnt_reg;
        emit              = 1'b0;
        pop               = 1'b0;
        take_right        = '0;
        rsp_next          = '0;
        rsp_next.status   = STS_OK;
        cell_ctrl.op      = CELL_HOLD;
        cell_ctrl.key_id  = req_reg.alarm_id;
        cell_ctrl.ins.due_time = req_reg.alarm_time;
        cell_ctrl.ins.id       = new_id;
        cell_ctrl.ins.owner    = tag_norm(req_reg.owner_name);

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = (saq_func_t'(req.func) == FN_EXPIRE) ? ST_EXPIRE : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit                 = 1'b1;
                    rsp_next.last_result = 1'b1;
                    state_next           = ST_IDLE;
                    case (req_reg.func)
                        FN_ADD:
                        begin
                            if (req_reg.alarm_time < req_reg.now_time)
                            begin
                                rsp_next.status = STS_PAST;
                            end
                            else if (occ_reg == OCC_W'(CAPACITY))
                            begin
                                rsp_next.status = STS_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op    = CELL_INSERT;
                                occ_next        = occ_reg + OCC_W'(1);
                                rsp_next.out_id = new_id;
                                if (ctr_reg <= CTR_W'(ID_LIMIT))
                                begin
                                    ctr_next = ctr_reg + CTR_W'(1);
                                end
                            end
                        end
                        FN_DELETE:
                        begin
                            if (!found)
                            begin
                                rsp_next.status = STS_NO_ID;
                            end
                            else if (!req_reg.override_owner
                                     && !tag_eq(req_reg.owner_name, sel_entry.owner))
                            begin
                                rsp_next.status = STS_NOT_OWNER;
                            end
                            else
                            begin
                                cell_ctrl.op    = CELL_REMOVE;
                                take_right      = rm_vec;
                                occ_next        = occ_reg - OCC_W'(1);
                                rsp_next.out_id = req_reg.alarm_id;
                            end
                        end
                        FN_FIND:
                        begin
                            if (!found)
                            begin
                                rsp_next.status = STS_NO_ID;
                            end
                            else
                            begin
                                rsp_next.out_id    = sel_entry.id;
                                rsp_next.out_time  = sel_entry.due_time;
                                rsp_next.out_owner = sel_entry.owner;
                            end
                        end
                        default:
                        begin
                            // Expire never runs here; drop back to idle with no result.
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            ST_EXPIRE:
            begin
                if (!head_due)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit                 = 1'b1;
                    pop                  = 1'b1;
                    cell_ctrl.op         = CELL_REMOVE;
                    take_right           = '1;
                    occ_next             = occ_reg - OCC_W'(1);
                    cnt_next             = cnt_reg + CNT_W'(1);
                    rsp_next.out_id      = cell_entry[0].id;
                    rsp_next.out_time    = cell_entry[0].due_time;
                    rsp_next.out_owner   = cell_entry[0].owner;
                    rsp_next.last_result = !next_due;
                    // Emptying the queue restarts id assignment.
                    if (occ_reg == OCC_W'(1))
                    begin
                        ctr_next = '0;
                    end
                    if (!next_due)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            ctr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            ctr_reg   <= ctr_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.func           <= saq_func_t'(req.func);
            req_reg.alarm_id       <= req.alarm_id;
            req_reg.alarm_time     <= req.alarm_time;
            req_reg.owner_name     <= req.owner_name;
            req_reg.override_owner <= req.override_owner;
            req_reg.now_time       <= req.now_time;
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_ctr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctr_reg <= CTR_W'(ID_LIMIT + 1))
        else $error("id counter ran past its limit");

    a_empty_resets_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && occ_reg == OCC_W'(1)) |=> (ctr_reg == '0 && occ_reg == '0))
        else $error("emptying pop did not clear the id counter");

    a_pop_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RESULT_LIMIT))
        else $error("expire popped more entries than allowed");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_free) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("single request did not finish with a result");
`endif

endmodule
